// ===== rtl/core/oes_pkg.sv =====
// ----------------------------------------------------------------------------
// oes_pkg
// types, widths and constants shared by the one-euro smoother blocks
// ----------------------------------------------------------------------------
`default_nettype none

package oes_pkg;

    localparam int VALUE_W     = 32;
    localparam int STEP_W      = 20;
    localparam int SPEED_W     = 48;
    localparam int MIN_FC_W    = 16;
    localparam int GAIN_W      = 24;
    localparam int FC_W        = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int ALPHA_FRAC  = 24;
    localparam int ALPHA_W     = ALPHA_FRAC + 1;
    localparam int CUT_SHIFT   = 8 + 16;
    localparam int MAG_W       = SPEED_W + 1;

    localparam int MUL_A_W     = 36;
    localparam int MUL_B_W     = 25;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam int DIV_Q_W     = 52;
    localparam int DIV_D_W     = 56;
    localparam int DIV_CNT_W   = 6;

    localparam logic [DIV_CNT_W-1:0] SPD_ITERS   = 6'd52;
    localparam logic [DIV_CNT_W-1:0] ALPHA_ITERS = 6'd25;

    localparam logic [18:0] TWO_PI_Q16   = 19'd411775;
    localparam logic [19:0] US_PER_S     = 20'd1000000;
    localparam logic [27:0] US_PER_S_Q8  = 28'd256000000;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE = 25'h1000000;
    localparam logic [DIV_Q_W-1:0]  KEEP_NUM  = {US_PER_S_Q8, 24'd0};
    localparam logic [DIV_D_W-1:0]  KEEP_REM  = DIV_D_W'(KEEP_NUM >> 25);
    localparam logic [DIV_Q_W-1:0]  KEEP_QUO  = KEEP_NUM << 27;

    localparam logic [MIN_FC_W-1:0] MIN_FC_RESET = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUTOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD_MUL,
        ST_SPD_DIV,
        ST_SPD_WAIT,
        ST_A_U,
        ST_A_HI,
        ST_A_LO,
        ST_A_DIV,
        ST_A_WAIT,
        ST_M_HI,
        ST_M_LO,
        ST_M_SUM,
        ST_C_LO,
        ST_C_HI,
        ST_C_SUM
    } t_state;

    typedef enum logic {
        PH_SPEED,
        PH_OUT
    } t_phase;

    typedef struct packed {
        logic [DIV_D_W-1:0]   rem_init;
        logic [DIV_Q_W-1:0]   quo_init;
        logic [DIV_CNT_W-1:0] iters;
        logic [DIV_D_W-1:0]   den;
    } t_div_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/oes_mul.sv =====
// ----------------------------------------------------------------------------
// oes_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module oes_mul (
    input  wire logic                        i_clk,
    input  wire logic [oes_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [oes_pkg::MUL_B_W-1:0] i_b,
    output logic      [oes_pkg::MUL_P_W-1:0] o_p
);

    logic [oes_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= oes_pkg::MUL_P_W'(i_a) * oes_pkg::MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/core/oes_div.sv =====
// ----------------------------------------------------------------------------
// oes_div
// restoring divider, one quotient bit per cycle, preloadable remainder
// ----------------------------------------------------------------------------
`default_nettype none

module oes_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire oes_pkg::t_div_cmd           i_cmd,
    output logic                             o_done,
    output logic      [oes_pkg::DIV_Q_W-1:0] o_quo
);

    logic [oes_pkg::DIV_D_W-1:0]   r_rem;
    logic [oes_pkg::DIV_Q_W-1:0]   r_quo;
    logic [oes_pkg::DIV_D_W-1:0]   r_den;
    logic [oes_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;

    logic [oes_pkg::DIV_D_W:0]     trial;
    logic [oes_pkg::DIV_D_W:0]     diff;
    logic                          ge;
    logic [oes_pkg::DIV_D_W-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_quo[oes_pkg::DIV_Q_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[oes_pkg::DIV_D_W-1:0] : trial[oes_pkg::DIV_D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_cmd.iters;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == oes_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_cmd.rem_init;
            r_quo <= i_cmd.quo_init;
            r_den <= i_cmd.den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[oes_pkg::DIV_Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== rtl/core/one_euro_adaptive_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// one_euro_adaptive_smoother_unit
// one-euro filter: speed low-pass at minimum cutoff, sample low-pass at a
// cutoff raised by beta times filtered speed
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       i_in_valid / o_in_stall, sample, step, clr  in
//  out      o_out_valid / i_out_stall, smoothed         out
//  cfg      i_cfg_valid / o_cfg_ready, index, data      in
//
//  pass-through beats (zero step, first after restart): result valid next cycle
//  a filtered beat has its result valid once the shared divider has run for the
//  speed quotient (52 steps) and for each of the two alphas (25 steps), with
//  multiplier and sequencer steps in between
//  one beat in flight; input stalls until the cycle after the result is taken
//  synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module one_euro_adaptive_smoother_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [oes_pkg::VALUE_W-1:0]   i_sample_value,
    input  wire logic        [oes_pkg::STEP_W-1:0]    i_step_time_us,
    input  wire logic                                 i_clear_history,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed      [oes_pkg::VALUE_W-1:0]   o_smoothed_value,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [oes_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [oes_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    oes_pkg::t_state r_state, n_state;
    oes_pkg::t_phase r_phase;

    logic        [oes_pkg::MIN_FC_W-1:0] r_min_fc;
    logic        [oes_pkg::GAIN_W-1:0]   r_gain;
    logic signed [oes_pkg::VALUE_W-1:0]  r_x;
    logic        [oes_pkg::STEP_W-1:0]   r_dt;
    logic signed [oes_pkg::VALUE_W-1:0]  r_prev_out;
    logic signed [oes_pkg::SPEED_W-1:0]  r_prev_spd;
    logic                                r_hist;
    logic signed [oes_pkg::SPEED_W-1:0]  r_dx;
    logic        [oes_pkg::FC_W-1:0]     r_fc;
    logic        [oes_pkg::DIV_Q_W-1:0]  r_u;
    logic        [oes_pkg::DIV_D_W-1:0]  r_w;
    logic        [oes_pkg::ALPHA_W-1:0]  r_alpha;
    logic        [oes_pkg::MAG_W-1:0]    r_part;
    logic        [55:0]                  r_plo;
    logic                                r_out_valid;
    logic signed [oes_pkg::VALUE_W-1:0]  r_out_data;

    logic                                in_accept;
    logic                                hist_eff;
    logic        [oes_pkg::MUL_A_W-1:0]  mul_a;
    logic        [oes_pkg::MUL_B_W-1:0]  mul_b;
    logic        [oes_pkg::MUL_P_W-1:0]  mul_p;
    logic                                div_start;
    oes_pkg::t_div_cmd                   div_cmd;
    logic                                div_done;
    logic        [oes_pkg::DIV_Q_W-1:0]  div_quo;

    logic signed [oes_pkg::VALUE_W:0]    spd_diff;
    logic                                spd_neg;
    logic        [oes_pkg::VALUE_W:0]    spd_mag;
    logic        [oes_pkg::SPEED_W-1:0]  sat_mag;
    logic signed [oes_pkg::SPEED_W-1:0]  dx_val;

    logic signed [oes_pkg::SPEED_W-1:0]  mv_prev;
    logic signed [oes_pkg::SPEED_W-1:0]  mv_target;
    logic signed [oes_pkg::MAG_W-1:0]    mv_diff;
    logic                                mv_neg;
    logic        [oes_pkg::MAG_W-1:0]    mv_mag;
    logic        [oes_pkg::MAG_W-1:0]    mv_part;
    logic        [oes_pkg::MAG_W-1:0]    mv_res;

    logic        [oes_pkg::SPEED_W-1:0]  emag;
    logic        [oes_pkg::MAG_W-1:0]    cut_term;
    logic        [oes_pkg::MAG_W:0]      cut_sum;
    logic        [oes_pkg::FC_W-1:0]     cut_val;

    logic        [oes_pkg::DIV_D_W-1:0]  alpha_den;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign hist_eff    = r_hist && !i_clear_history;
    assign o_in_stall  = !i_rst_n || (r_state != oes_pkg::ST_IDLE) || r_out_valid;
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_smoothed_value = r_out_data;

    oes_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    oes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_cmd   (div_cmd),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // speed quotient and saturation
    always_comb begin
        spd_diff = {r_x[oes_pkg::VALUE_W-1], r_x}
                 - {r_prev_out[oes_pkg::VALUE_W-1], r_prev_out};
        spd_neg  = spd_diff[oes_pkg::VALUE_W];
        spd_mag  = spd_neg ? -spd_diff : spd_diff;
        if (spd_neg) begin
            sat_mag = (div_quo > {4'd0, 1'b1, 47'd0}) ? {1'b1, 47'd0}
                                                     : div_quo[oes_pkg::SPEED_W-1:0];
            dx_val  = -sat_mag;
        end else begin
            sat_mag = (div_quo > {5'd0, {47{1'b1}}}) ? {1'b0, {47{1'b1}}}
                                                     : div_quo[oes_pkg::SPEED_W-1:0];
            dx_val  = sat_mag;
        end
    end

    // move toward target by alpha
    always_comb begin
        if (r_phase == oes_pkg::PH_SPEED) begin
            mv_prev   = r_prev_spd;
            mv_target = r_dx;
        end else begin
            mv_prev   = oes_pkg::SPEED_W'(r_prev_out);
            mv_target = oes_pkg::SPEED_W'(r_x);
        end
        mv_diff = {mv_target[oes_pkg::SPEED_W-1], mv_target}
                - {mv_prev[oes_pkg::SPEED_W-1], mv_prev};
        mv_neg  = mv_diff[oes_pkg::MAG_W-1];
        mv_mag  = mv_neg ? -mv_diff : mv_diff;
        mv_part = r_part + oes_pkg::MAG_W'(mul_p[48:24]);
        mv_res  = mv_neg ? {mv_prev[oes_pkg::SPEED_W-1], mv_prev} - mv_part
                         : {mv_prev[oes_pkg::SPEED_W-1], mv_prev} + mv_part;
    end

    // cutoff from filtered speed, and alpha divisor
    always_comb begin
        emag     = r_prev_spd[oes_pkg::SPEED_W-1] ? -r_prev_spd : r_prev_spd;
        cut_term = oes_pkg::MAG_W'({mul_p[39:0], 8'd0})
                 + oes_pkg::MAG_W'(r_plo[55:oes_pkg::CUT_SHIFT]);
        cut_sum  = oes_pkg::MAG_W'(r_min_fc) + (oes_pkg::MAG_W + 1)'(cut_term);
        cut_val  = (cut_sum[oes_pkg::MAG_W:oes_pkg::FC_W] != '0) ? '1
                                                                 : cut_sum[oes_pkg::FC_W-1:0];
        alpha_den = r_w + oes_pkg::DIV_D_W'(mul_p[34:16])
                  + oes_pkg::DIV_D_W'(oes_pkg::US_PER_S_Q8);
    end

    // multiplier operands and divider commands
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_cmd   = '0;
        unique case (r_state)
            oes_pkg::ST_SPD_MUL: begin
                mul_a = oes_pkg::MUL_A_W'(spd_mag);
                mul_b = oes_pkg::MUL_B_W'(oes_pkg::US_PER_S);
            end
            oes_pkg::ST_SPD_DIV: begin
                div_start        = 1'b1;
                div_cmd.rem_init = '0;
                div_cmd.quo_init = mul_p[oes_pkg::DIV_Q_W-1:0];
                div_cmd.iters    = oes_pkg::SPD_ITERS;
                div_cmd.den      = oes_pkg::DIV_D_W'(r_dt);
            end
            oes_pkg::ST_A_U: begin
                mul_a = oes_pkg::MUL_A_W'(r_fc);
                mul_b = oes_pkg::MUL_B_W'(r_dt);
            end
            oes_pkg::ST_A_HI: begin
                mul_a = mul_p[51:16];
                mul_b = oes_pkg::MUL_B_W'(oes_pkg::TWO_PI_Q16);
            end
            oes_pkg::ST_A_LO: begin
                mul_a = oes_pkg::MUL_A_W'(r_u[15:0]);
                mul_b = oes_pkg::MUL_B_W'(oes_pkg::TWO_PI_Q16);
            end
            oes_pkg::ST_A_DIV: begin
                div_start        = 1'b1;
                div_cmd.rem_init = oes_pkg::KEEP_REM;
                div_cmd.quo_init = oes_pkg::KEEP_QUO;
                div_cmd.iters    = oes_pkg::ALPHA_ITERS;
                div_cmd.den      = alpha_den;
            end
            oes_pkg::ST_M_HI: begin
                mul_a = oes_pkg::MUL_A_W'(mv_mag[48:24]);
                mul_b = r_alpha;
            end
            oes_pkg::ST_M_LO: begin
                mul_a = oes_pkg::MUL_A_W'(mv_mag[23:0]);
                mul_b = r_alpha;
            end
            oes_pkg::ST_C_LO: begin
                mul_a = oes_pkg::MUL_A_W'(emag[31:0]);
                mul_b = oes_pkg::MUL_B_W'(r_gain);
            end
            oes_pkg::ST_C_HI: begin
                mul_a = oes_pkg::MUL_A_W'(emag[47:32]);
                mul_b = oes_pkg::MUL_B_W'(r_gain);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oes_pkg::ST_IDLE: begin
                if (in_accept && (i_step_time_us != '0) && hist_eff) begin
                    n_state = oes_pkg::ST_SPD_MUL;
                end
            end
            oes_pkg::ST_SPD_MUL:  n_state = oes_pkg::ST_SPD_DIV;
            oes_pkg::ST_SPD_DIV:  n_state = oes_pkg::ST_SPD_WAIT;
            oes_pkg::ST_SPD_WAIT: begin
                if (div_done) begin
                    n_state = oes_pkg::ST_A_U;
                end
            end
            oes_pkg::ST_A_U:      n_state = oes_pkg::ST_A_HI;
            oes_pkg::ST_A_HI:     n_state = oes_pkg::ST_A_LO;
            oes_pkg::ST_A_LO:     n_state = oes_pkg::ST_A_DIV;
            oes_pkg::ST_A_DIV:    n_state = oes_pkg::ST_A_WAIT;
            oes_pkg::ST_A_WAIT: begin
                if (div_done) begin
                    n_state = oes_pkg::ST_M_HI;
                end
            end
            oes_pkg::ST_M_HI:     n_state = oes_pkg::ST_M_LO;
            oes_pkg::ST_M_LO:     n_state = oes_pkg::ST_M_SUM;
            oes_pkg::ST_M_SUM: begin
                n_state = (r_phase == oes_pkg::PH_SPEED) ? oes_pkg::ST_C_LO
                                                         : oes_pkg::ST_IDLE;
            end
            oes_pkg::ST_C_LO:     n_state = oes_pkg::ST_C_HI;
            oes_pkg::ST_C_HI:     n_state = oes_pkg::ST_C_SUM;
            oes_pkg::ST_C_SUM:    n_state = oes_pkg::ST_A_U;
            default:              n_state = oes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oes_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fc    <= oes_pkg::MIN_FC_RESET;
            r_gain      <= '0;
            r_prev_out  <= '0;
            r_prev_spd  <= '0;
            r_hist      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == oes_pkg::CFG_MIN_CUTOFF) begin
                    r_min_fc <= i_cfg_data[oes_pkg::MIN_FC_W-1:0];
                end else if (i_cfg_index == oes_pkg::CFG_SPEED_GAIN) begin
                    r_gain <= i_cfg_data;
                end
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                if (i_step_time_us == '0) begin
                    if (i_clear_history) begin
                        r_hist     <= 1'b0;
                        r_prev_out <= '0;
                        r_prev_spd <= '0;
                    end
                    r_out_valid <= 1'b1;
                end else if (!hist_eff) begin
                    r_prev_out  <= i_sample_value;
                    r_prev_spd  <= '0;
                    r_hist      <= 1'b1;
                    r_out_valid <= 1'b1;
                end
            end
            if (r_state == oes_pkg::ST_M_SUM) begin
                if (r_phase == oes_pkg::PH_SPEED) begin
                    r_prev_spd <= mv_res[oes_pkg::SPEED_W-1:0];
                end else begin
                    r_prev_out  <= mv_res[oes_pkg::VALUE_W-1:0];
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x        <= i_sample_value;
            r_dt       <= i_step_time_us;
            r_out_data <= i_sample_value;
        end
        unique case (r_state)
            oes_pkg::ST_SPD_WAIT: begin
                r_dx    <= dx_val;
                r_fc    <= oes_pkg::FC_W'(r_min_fc);
                r_phase <= oes_pkg::PH_SPEED;
            end
            oes_pkg::ST_A_HI:   r_u     <= mul_p[oes_pkg::DIV_Q_W-1:0];
            oes_pkg::ST_A_LO:   r_w     <= mul_p[oes_pkg::DIV_D_W-1:0];
            oes_pkg::ST_A_WAIT: r_alpha <= oes_pkg::ALPHA_ONE - div_quo[oes_pkg::ALPHA_W-1:0];
            oes_pkg::ST_M_LO:   r_part  <= mul_p[oes_pkg::MAG_W-1:0];
            oes_pkg::ST_M_SUM: begin
                if (r_phase == oes_pkg::PH_OUT) begin
                    r_out_data <= mv_res[oes_pkg::VALUE_W-1:0];
                end
            end
            oes_pkg::ST_C_HI:   r_plo   <= mul_p[55:0];
            oes_pkg::ST_C_SUM: begin
                r_fc    <= cut_val;
                r_phase <= oes_pkg::PH_OUT;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/oes_checker.sv =====
// ----------------------------------------------------------------------------
// oes_checker
// port-level checks on the one-euro smoother, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module oes_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_in_valid,
    input wire logic                                 o_in_stall,
    input wire logic signed [oes_pkg::VALUE_W-1:0]   i_sample_value,
    input wire logic        [oes_pkg::STEP_W-1:0]    i_step_time_us,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_stall,
    input wire logic signed [oes_pkg::VALUE_W-1:0]   o_smoothed_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken while first in flight");

    a_zero_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_step_time_us == '0)
        |=> o_out_valid && (o_smoothed_value == $past(i_sample_value)))
        else $error("zero step not passed through");

endmodule

bind one_euro_adaptive_smoother_unit oes_checker u_oes_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_sample_value   (i_sample_value),
    .i_step_time_us   (i_step_time_us),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_smoothed_value (o_smoothed_value)
);

`default_nettype wire

// ===== bench/one_euro_adaptive_smoother_unit_test.sv =====
// ----------------------------------------------------------------------------
// one_euro_adaptive_smoother_unit_test
// self-checking bench: directed and random samples through the smoother under
// several cutoff and gain values, each result checked against a predictor
// ----------------------------------------------------------------------------
`default_nettype none

module one_euro_adaptive_smoother_unit_test;

    typedef struct {
        logic signed [oes_pkg::VALUE_W-1:0] value;
        logic        [oes_pkg::STEP_W-1:0]  step_us;
        logic                               clear;
    } t_sample_beat;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic signed [oes_pkg::VALUE_W-1:0] i_sample_value = '0;
    logic        [oes_pkg::STEP_W-1:0]  i_step_time_us = '0;
    logic                               i_clear_history = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic signed [oes_pkg::VALUE_W-1:0] o_smoothed_value;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [oes_pkg::CFG_IDX_W-1:0]      i_cfg_index = oes_pkg::CFG_MIN_CUTOFF;
    logic [oes_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;

    one_euro_adaptive_smoother_unit DUT (.*);

    always #1 i_clk = ~i_clk;

    t_sample_beat                       pending_beats[$];
    logic signed [oes_pkg::VALUE_W-1:0] expected_smooth[$];
    int                                 idle_mode = 0;
    int                                 beats_sent = 0;
    int                                 results_checked = 0;
    int                                 mismatches = 0;
    int                                 cfg_writes = 0;
    int                                 hold_left = 0;
    bit                                 held_once = 0;

    // predictor state and register copies
    logic [127:0] min_fc = 128'd256;
    logic [127:0] gain = 128'd0;
    longint       last_out = 0;
    longint       last_speed = 0;
    bit           have_history = 0;

    function automatic logic [127:0] alpha_of(logic [127:0] fc, logic [127:0] dt);
        logic [127:0] w;
        logic [127:0] keep;
        w = (fc * dt * 128'd411775) >> 16;
        keep = (128'd256000000 << 24) / (w + 128'd256000000);
        return (128'd1 << 24) - keep;
    endfunction

    function automatic longint glide(longint prev, longint target, logic [127:0] a);
        longint       d;
        logic [127:0] m;
        logic [127:0] part;
        d = target - prev;
        m = (d < 0) ? 128'(-d) : 128'(d);
        part = (m * a) >> 24;
        return (d < 0) ? prev - longint'(part) : prev + longint'(part);
    endfunction

    function automatic logic [oes_pkg::VALUE_W-1:0] smooth_predict(t_sample_beat b);
        longint       x;
        longint       d;
        longint       dx;
        longint       edx;
        logic [127:0] mag;
        logic [127:0] fc;
        x = longint'(b.value);
        if (b.clear) begin
            last_out = 0;
            last_speed = 0;
            have_history = 0;
        end
        if (b.step_us == 0) return b.value;
        if (!have_history) begin
            last_out = x;
            last_speed = 0;
            have_history = 1;
            return b.value;
        end
        d = x - last_out;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        mag = mag * 128'd1000000 / 128'(b.step_us);
        if (d < 0) begin
            if (mag > (128'd1 << 47)) mag = 128'd1 << 47;
            dx = -longint'(mag);
        end else begin
            if (mag > (128'd1 << 47) - 1) mag = (128'd1 << 47) - 1;
            dx = longint'(mag);
        end
        edx = glide(last_speed, dx, alpha_of(min_fc, 128'(b.step_us)));
        mag = (edx < 0) ? 128'(-edx) : 128'(edx);
        fc = min_fc + ((gain * mag) >> 24);
        if (fc > 128'hFFFF_FFFF) fc = 128'hFFFF_FFFF;
        last_speed = edx;
        last_out = glide(last_out, x, alpha_of(fc, 128'(b.step_us)));
        return last_out[oes_pkg::VALUE_W-1:0];
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            0: return $urandom_range(99) < 22;
            1: return $urandom_range(99) < 59;
            default: return 0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            0: return $urandom_range(99) < 59;
            1: return $urandom_range(99) < 22;
            default: return 0;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_sample_beat b;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                b.value = i_sample_value;
                b.step_us = i_step_time_us;
                b.clear = i_clear_history;
                expected_smooth.push_back(smooth_predict(b));
                beats_sent++;
            end
            if (pending_beats.size() > 0 && !sender_idles()) begin
                b = pending_beats.pop_front();
                i_in_valid <= 1'b1;
                i_sample_value <= b.value;
                i_step_time_us <= b.step_us;
                i_clear_history <= b.clear;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold, counted on its own
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!held_once && beats_sent >= 40) begin
            held_once <= 1'b1;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        logic signed [oes_pkg::VALUE_W-1:0] want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_smooth.size() == 0) begin
                    $error("unexpected beat: smoothed_value %0d", o_smoothed_value);
                    mismatches++;
                end else begin
                    want = expected_smooth.pop_front();
                    results_checked++;
                    if (o_smoothed_value !== want) begin
                        $error("smoothed_value: expected %0d, got %0d", want,
                               o_smoothed_value);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= receiver_idles();
            end
        end
    end

    task automatic queue_beat(logic signed [oes_pkg::VALUE_W-1:0] v,
                              logic [oes_pkg::STEP_W-1:0] dt, logic clr);
        t_sample_beat b;
        b.value = v;
        b.step_us = dt;
        b.clear = clr;
        pending_beats.push_back(b);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || i_in_valid || expected_smooth.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [oes_pkg::CFG_IDX_W-1:0] idx,
                             logic [oes_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == oes_pkg::CFG_MIN_CUTOFF) min_fc = 128'(data[oes_pkg::MIN_FC_W-1:0]);
        else gain = 128'(data);
        cfg_writes++;
    endtask

    task automatic queue_random(int count);
        logic signed [oes_pkg::VALUE_W-1:0] v;
        logic [oes_pkg::STEP_W-1:0]         dt;
        logic                               clr;
        v = oes_pkg::VALUE_W'($urandom);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: v = oes_pkg::VALUE_W'($urandom);
                1, 2: v = v + $signed($urandom_range(2000000)) - 1000000;
                default: v = v + $signed($urandom_range(20000)) - 10000;
            endcase
            case ($urandom_range(19))
                0: dt = '0;
                1: dt = oes_pkg::STEP_W'($urandom);
                2: dt = {oes_pkg::STEP_W{1'b1}};
                3: dt = oes_pkg::STEP_W'($urandom_range(1, 16));
                default: dt = oes_pkg::STEP_W'($urandom_range(500, 40000));
            endcase
            clr = ($urandom_range(24) == 0);
            queue_beat(v, dt, clr);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: first sample, extremes, zero step, clears
        queue_beat(32'sd0, 20'd1000, 1'b0);
        queue_beat(32'sh7FFF_FFFF, 20'd1000, 1'b0);
        queue_beat(-32'sh8000_0000, 20'd1, 1'b0);
        queue_beat(32'sh0001_0000, 20'd0, 1'b0);
        queue_beat(32'sh1234_5678, 20'd0, 1'b1);
        queue_beat(32'sh0002_0000, 20'd1, 1'b1);
        queue_beat(32'sh0003_0000, 20'hFFFFF, 1'b0);
        queue_beat(-32'sh0001_0000, 20'd16667, 1'b0);
        wait_drained();

        write_reg(oes_pkg::CFG_SPEED_GAIN, 24'hFF_FFFF);
        write_reg(oes_pkg::CFG_MIN_CUTOFF, 24'hFFFF);
        queue_beat(32'sh0001_0000, 20'd1000, 1'b1);
        queue_beat(32'sh7FFF_FFFF, 20'd1, 1'b0);
        queue_beat(-32'sh8000_0000, 20'd1, 1'b0);
        queue_beat(32'sh0000_8000, 20'hFFFFF, 1'b0);
        queue_beat(32'sh0000_8001, 20'd3, 1'b0);
        wait_drained();

        write_reg(oes_pkg::CFG_MIN_CUTOFF, 24'd1);
        write_reg(oes_pkg::CFG_SPEED_GAIN, 24'd0);
        queue_beat(32'sh0000_0000, 20'd100, 1'b1);
        queue_beat(32'sh4000_0000, 20'd100, 1'b0);
        queue_beat(-32'sh4000_0000, 20'hFFFFF, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            idle_mode = ph % 3;
            write_reg(oes_pkg::CFG_MIN_CUTOFF, (ph == 0) ? 24'd1 : (ph == 5) ? 24'hFFFF
                                      : 24'($urandom_range(1, 65535)));
            write_reg(oes_pkg::CFG_SPEED_GAIN, (ph == 1) ? 24'hFF_FFFF : (ph == 2) ? 24'd0
                                      : 24'($urandom));
            queue_beat(oes_pkg::VALUE_W'($urandom),
                       oes_pkg::STEP_W'($urandom_range(1, 20000)), 1'b1);
            queue_random(80);
            wait_drained();
        end

        $display("covered %0d sample beats, %0d results checked, %0d register writes",
                 beats_sent, results_checked, cfg_writes);
        $display("cutoff and gain from minimum to maximum, zero steps, clears, long hold");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
